FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types and constants for the character-cell text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_FG_COLOR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BG_COLOR = 3'd4;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [3:0] RESET_FG     = 4'd7;
   localparam logic [3:0] RESET_BG     = 4'd0;
   localparam logic [15:0] RESET_CELL  = {RESET_BG, RESET_FG, SPACE_CODE};

   typedef struct packed {
      logic [3:0] bg;
      logic [3:0] fg;
   } tcw_color_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_PUT,
      ST_SCROLL,
      ST_FILL,
      ST_RDWAIT,
      ST_DONE
   } tcw_state_type;

endpackage

FILE: hw/rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// Text console channel interfaces
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] char_code;
   logic [4:0] cell_row;
   logic [6:0] cell_col;

   modport source (output valid, output operation, output char_code, output cell_row,
                   output cell_col, input ready);
   modport sink (input valid, input operation, input char_code, input cell_row,
                 input cell_col, output ready);
endinterface

interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  cursor_row;
   logic [6:0]  cursor_col;
   logic [10:0] cursor_pos;
   logic [7:0]  read_char;
   logic [7:0]  read_attr;

   modport source (output valid, output cursor_row, output cursor_col, output cursor_pos,
                   output read_char, output read_attr, input ready);
   modport sink (input valid, input cursor_row, input cursor_col, input cursor_pos,
                 input read_char, input read_attr, output ready);
endinterface

FILE: hw/rtl/tcw_csr.sv
// ----------------------------------------------------------------------------
// Text console register block
// APB-style port holding the foreground and background color registers.
// ----------------------------------------------------------------------------
module tcw_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output tcw_pkg::tcw_color_type          color
);
   import tcw_pkg::*;

   tcw_color_type color_ff;
   tcw_color_type color_in;
   logic          wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign color  = color_ff;

   always_comb begin
      color_in = color_ff;
      if (wr_en) begin
         unique case (paddr)
            CSR_FG_COLOR: color_in.fg = pwdata[3:0];
            CSR_BG_COLOR: color_in.bg = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         CSR_FG_COLOR: prdata = CSR_DATA_W'(color_ff.fg);
         CSR_BG_COLOR: prdata = CSR_DATA_W'(color_ff.bg);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff.fg <= RESET_FG;
         color_ff.bg <= RESET_BG;
      end else begin
         color_ff <= color_in;
      end
   end

   wr_no_reach: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> color_ff == $past(color_ff))
      else $error("color registers changed without a write transaction");

   fg_wr: assert property (@(posedge clock) disable iff (reset)
      wr_en && paddr == CSR_FG_COLOR |=> color_ff.fg == $past(pwdata[3:0]))
      else $error("foreground color write was lost");

   bg_hold: assert property (@(posedge clock) disable iff (reset)
      wr_en && paddr == CSR_FG_COLOR |=> $stable(color_ff.bg))
      else $error("foreground write disturbed the background color");

endmodule

FILE: hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console with a ROWS by COLS cell memory and a write cursor.
// ----------------------------------------------------------------------------
// A plain put passes through EXEC, PUT and DONE, and an in-range read through EXEC,
// RDWAIT and DONE. A clear, or a new line taken on the bottom row, sweeps the cell
// memory one cell per cycle through the single write port.
// One transaction is processed at a time; a request is accepted only in ST_IDLE.
// After reset a clearing pass fills the memory with blank cells, during which no
// request is accepted; color registers are writable at once.
module text_console_writer #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   tcw_req_if.sink                         req_if,
   tcw_rsp_if.source                       rsp_if,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLS;
   localparam int COPIES = CELLS - COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS + 1);
   localparam int POS_W  = $clog2(CELLS + 1);

   tcw_color_type color;

   tcw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .color   (color)
   );

   tcw_state_type      state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]         op_ff, op_in;
   logic [7:0]         ch_ff, ch_in;
   logic [4:0]         rr_ff, rr_in;
   logic [6:0]         rc_ff, rc_in;
   logic               copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0]  copy_addr_ff, copy_addr_in;
   logic [15:0]        rd_hold_ff, rd_hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         rsp_row_ff, rsp_row_in;
   logic [6:0]         rsp_col_ff, rsp_col_in;
   logic [10:0]        rsp_pos_ff, rsp_pos_in;
   logic [15:0]        rsp_cell_ff, rsp_cell_in;

   logic [15:0]        mem [CELLS];
   logic [15:0]        rd_data_ff;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [15:0]        mem_wdata;

   logic               req_fire, rsp_load;
   logic               nl_need, row_last, put_pend, rd_in_range;
   logic               copy_done, fill_done, init_done;
   logic [POS_W-1:0]   pos;
   logic [15:0]        blank;

   assign req_fire    = req_if.valid && req_if.ready;
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign row_last    = row_ff == ROW_W'(ROWS - 1);
   assign nl_need     = (ch_ff == NEWLINE_CODE) || (32'(col_ff) >= COLS);
   assign put_pend    = (op_ff == OP_PUT) && (ch_ff != NEWLINE_CODE);
   assign rd_in_range = (32'(rr_ff) < ROWS) && (32'(rc_ff) < COLS);
   assign copy_done   = cnt_ff == ADDR_W'(COPIES);
   assign fill_done   = cnt_ff == ADDR_W'(CELLS - 1);
   assign init_done   = fill_done;
   assign pos         = POS_W'(row_ff) * POS_W'(COLS) + POS_W'(col_ff);
   assign blank       = {color.bg, color.fg, SPACE_CODE};

   assign req_if.ready      = state_ff == ST_IDLE;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.cursor_row = rsp_row_ff;
   assign rsp_if.cursor_col = rsp_col_ff;
   assign rsp_if.cursor_pos = rsp_pos_ff;
   assign rsp_if.read_char  = rsp_cell_ff[7:0];
   assign rsp_if.read_attr  = rsp_cell_ff[15:8];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:   if (init_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_fire) state_in = ST_EXEC;
         ST_EXEC: begin
            case (op_ff)
               OP_PUT: begin
                  if (!nl_need) begin
                     state_in = ST_PUT;
                  end else if (row_last) begin
                     state_in = ST_SCROLL;
                  end else begin
                     state_in = put_pend ? ST_PUT : ST_DONE;
                  end
               end
               OP_CLEAR: state_in = ST_FILL;
               OP_READ:  state_in = rd_in_range ? ST_RDWAIT : ST_DONE;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_PUT:    state_in = ST_DONE;
         ST_SCROLL: if (copy_done) state_in = ST_FILL;
         ST_FILL:   if (fill_done) state_in = put_pend ? ST_PUT : ST_DONE;
         ST_RDWAIT: state_in = ST_DONE;
         ST_DONE:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_INIT;
      endcase
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      rr_in        = rr_ff;
      rc_in        = rc_ff;
      copy_pend_in = 1'b0;
      copy_addr_in = copy_addr_ff;
      rd_hold_in   = rd_hold_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = blank;
      mem_re       = 1'b0;
      mem_raddr    = cnt_ff + ADDR_W'(COLS);

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = RESET_CELL;
            cnt_in    = cnt_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in = req_if.operation;
               ch_in = req_if.char_code;
               rr_in = req_if.cell_row;
               rc_in = req_if.cell_col;
            end
         end
         ST_EXEC: begin
            rd_hold_in = '0;
            cnt_in     = '0;
            case (op_ff)
               OP_PUT: begin
                  if (nl_need) begin
                     col_in = '0;
                     if (!row_last) row_in = row_ff + ROW_W'(1);
                  end
               end
               OP_CLEAR: begin
                  row_in = '0;
                  col_in = '0;
               end
               OP_READ: begin
                  mem_re    = rd_in_range;
                  mem_raddr = ADDR_W'(ADDR_W'(rr_ff) * ADDR_W'(COLS) + ADDR_W'(rc_ff));
               end
               default: ;
            endcase
         end
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(pos);
            mem_wdata = {color.bg, color.fg, ch_ff};
            col_in    = col_ff + COL_W'(1);
         end
         ST_SCROLL: begin
            if (!copy_done) begin
               mem_re       = 1'b1;
               copy_pend_in = 1'b1;
               copy_addr_in = cnt_ff;
               cnt_in       = cnt_ff + ADDR_W'(1);
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + ADDR_W'(1);
         end
         ST_RDWAIT: rd_hold_in = rd_data_ff;
         ST_DONE: ;
         default: ;
      endcase

      if (copy_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_addr_ff;
         mem_wdata = rd_data_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cell_in  = rsp_cell_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = 5'(row_ff);
         rsp_col_in   = 7'(col_ff);
         rsp_pos_in   = 11'(pos);
         rsp_cell_in  = rd_hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      rr_ff        <= rr_in;
      rc_ff        <= rc_in;
      copy_addr_ff <= copy_addr_in;
      rd_hold_ff   <= rd_hold_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_cell_ff  <= rsp_cell_in;
   end

   cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) <= COLS) && (32'(row_ff) < ROWS))
      else $error("write cursor left the screen");

   put_in_line: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUT |-> 32'(col_ff) < COLS)
      else $error("character stored past the last column");

   copy_from_scroll: assert property (@(posedge clock) disable iff (reset)
      copy_pend_ff |-> $past(state_ff == ST_SCROLL))
      else $error("scroll copy write outside a scroll");

   rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule
